[rtl/core/wfd_pkg.sv]
// Package for the wall follower drive controller: payload structs, mode and
// command codes, speed constants and the configuration register map.
// No dependencies; every file of the block imports it.
package wfd_pkg;

  // Field widths.
  localparam int unsigned DistW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TcfgW  = 16;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned CntW   = 8;

  // Configuration port geometry: eight 32-bit registers at word addresses.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register map, by index.
  localparam logic [2:0] REG_FRONT_STOP   = 3'd0;
  localparam logic [2:0] REG_FRONT_SLOW   = 3'd1;
  localparam logic [2:0] REG_FRONT_CLEAR  = 3'd2;
  localparam logic [2:0] REG_SIDE_OPEN    = 3'd3;
  localparam logic [2:0] REG_SIDE_ENTER   = 3'd4;
  localparam logic [2:0] REG_SIDE_NEAR    = 3'd5;
  localparam logic [2:0] REG_TURN_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_POST_TURN    = 3'd7;

  // Motor command codes.
  localparam logic [2:0] ACT_HOLD    = 3'd0;
  localparam logic [2:0] ACT_FWD     = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_SPIN_L  = 3'd3;
  localparam logic [2:0] ACT_SPIN_R  = 3'd4;
  localparam logic [2:0] ACT_BRAKE_L = 3'd5;
  localparam logic [2:0] ACT_BRAKE_R = 3'd6;

  // Turn event codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LEFT  = 2'd1;
  localparam logic [1:0] EV_RIGHT = 2'd2;
  localparam logic [1:0] EV_DEAD  = 2'd3;

  // Mode codes as reported on the result.
  localparam logic [2:0] MODE_CODE_DRIVE = 3'd0;
  localparam logic [2:0] MODE_CODE_PRE   = 3'd1;
  localparam logic [2:0] MODE_CODE_LEFT  = 3'd2;
  localparam logic [2:0] MODE_CODE_RIGHT = 3'd3;
  localparam logic [2:0] MODE_CODE_POST  = 3'd4;

  // Wheel speeds and steering offsets.
  localparam logic [SpeedW-1:0] SPEED_FAST     = 10'd600;
  localparam logic [SpeedW-1:0] SPEED_SLOW     = 10'd360;
  localparam logic [SpeedW-1:0] SPEED_APPROACH = 10'd260;
  localparam logic [SpeedW-1:0] STEER_SMALL    = 10'd55;
  localparam logic [SpeedW-1:0] STEER_STRONG   = 10'd120;
  localparam logic [DistW:0]    CENTRE_BAND    = 13'd3;

  // Controller mode, one-hot.
  typedef enum logic [4:0] {
    MODE_DRIVE = 5'b00001,
    MODE_PRE   = 5'b00010,
    MODE_LEFT  = 5'b00100,
    MODE_RIGHT = 5'b01000,
    MODE_POST  = 5'b10000
  } mode_e;

  // One sensor tick.
  typedef struct packed {
    logic [DistW-1:0] front_dist;
    logic [DistW-1:0] left_dist;
    logic [DistW-1:0] right_dist;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  // One motor command.
  typedef struct packed {
    logic [2:0]        motor_action;
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
    logic [1:0]        turn_event;
    logic [CntW-1:0]   turn_total;
    logic [2:0]        mode_now;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [DistW-1:0] stop_dist;
    logic [DistW-1:0] slow_dist;
    logic [DistW-1:0] clear_dist;
    logic [DistW-1:0] open_dist;
    logic [DistW-1:0] enter_dist;
    logic [DistW-1:0] near_dist;
    logic [TcfgW-1:0] turn_limit;
    logic [TcfgW-1:0] settle_time;
  } cfg_t;

  // Controller state carried from tick to tick.
  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] turn_start;
    logic [CntW-1:0]  turn_cnt;
  } state_t;

  // Reported code of a one-hot mode.
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_DRIVE: code = MODE_CODE_DRIVE;
      MODE_PRE:   code = MODE_CODE_PRE;
      MODE_LEFT:  code = MODE_CODE_LEFT;
      MODE_RIGHT: code = MODE_CODE_RIGHT;
      MODE_POST:  code = MODE_CODE_POST;
      default:    code = MODE_CODE_DRIVE;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/wall_follower_drive_fsm.sv]
// Top level of the wall follower drive controller.
// Depends on wfd_pkg, wfd_regs and wfd_step.

// The controller takes one sensor tick (front, left, right distance and a
// millisecond timestamp) per clock cycle and returns exactly one motor command
// for each tick, in order. A tick is held in an input register, the decision
// logic runs on it together with the stored mode, turn start time and turn
// counter, and the command lands in a result register in the same cycle as
// the state update; while the result side stalls, the tick waits in the input
// register. A new tick can follow every cycle while the result side keeps
// taking commands. Configuration registers are to be written over the
// APB-style port only while no tick is in flight; the block itself does not
// enforce this. They take effect from the next tick.
module wall_follower_drive_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Sensor ticks.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  wfd_pkg::in_item_t         in_data_i,
  // Motor commands.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output wfd_pkg::out_item_t        out_data_o,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wfd_pkg::AddrW-1:0] paddr,
  input  logic [wfd_pkg::DataW-1:0] pwdata,
  output logic [wfd_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import wfd_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q;
  logic      out_vld_q, out_vld_d;
  state_t    state_q, state_d;
  out_item_t res;
  logic      in_xfer, adv;

  wfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wfd_step u_step (
    .item_i  (in_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .res_o   (res),
    .state_o (state_d)
  );

  // The held tick is processed when the result register is free or draining.
  assign adv        = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | adv;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.mode       <= MODE_DRIVE;
      state_q.turn_start <= '0;
      state_q.turn_cnt   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A waiting tick is never overwritten while the result side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("input register accepts a transfer while it cannot drain");

  // A pre-turn tick advances the turn counter by one or two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && state_q.mode == MODE_PRE) |=>
      (state_q.turn_cnt == $past(state_q.turn_cnt) + 8'd1) ||
      (state_q.turn_cnt == $past(state_q.turn_cnt) + 8'd2))
    else $error("turn counter step on pre-turn tick is wrong");

  // Finishing a turn restarts the timer at that tick's timestamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (state_q.mode == MODE_LEFT || state_q.mode == MODE_RIGHT) &&
     state_d.mode == MODE_POST) |=>
      (state_q.turn_start == $past(in_q.now_ms)))
    else $error("turn start not restarted on turn finish");

endmodule

[rtl/core/wfd_regs.sv]
// Configuration register file of the wall follower drive controller,
// written and read over an APB-style port. Depends on wfd_pkg.
module wfd_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wfd_pkg::AddrW-1:0] paddr,
  input  logic [wfd_pkg::DataW-1:0] pwdata,
  output logic [wfd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output wfd_pkg::cfg_t             cfg_o
);
  import wfd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Register write decode; the access phase of a write transfer commits it.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRONT_STOP:   cfg_d.stop_dist   = pwdata[DistW-1:0];
        REG_FRONT_SLOW:   cfg_d.slow_dist   = pwdata[DistW-1:0];
        REG_FRONT_CLEAR:  cfg_d.clear_dist  = pwdata[DistW-1:0];
        REG_SIDE_OPEN:    cfg_d.open_dist   = pwdata[DistW-1:0];
        REG_SIDE_ENTER:   cfg_d.enter_dist  = pwdata[DistW-1:0];
        REG_SIDE_NEAR:    cfg_d.near_dist   = pwdata[DistW-1:0];
        REG_TURN_TIMEOUT: cfg_d.turn_limit  = pwdata[TcfgW-1:0];
        REG_POST_TURN:    cfg_d.settle_time = pwdata[TcfgW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_dist   <= 12'd26;
      cfg_q.slow_dist   <= 12'd35;
      cfg_q.clear_dist  <= 12'd30;
      cfg_q.open_dist   <= 12'd35;
      cfg_q.enter_dist  <= 12'd25;
      cfg_q.near_dist   <= 12'd8;
      cfg_q.turn_limit  <= 16'd900;
      cfg_q.settle_time <= 16'd250;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux, zero-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_FRONT_STOP:   prdata = {{(DataW-DistW){1'b0}}, cfg_q.stop_dist};
      REG_FRONT_SLOW:   prdata = {{(DataW-DistW){1'b0}}, cfg_q.slow_dist};
      REG_FRONT_CLEAR:  prdata = {{(DataW-DistW){1'b0}}, cfg_q.clear_dist};
      REG_SIDE_OPEN:    prdata = {{(DataW-DistW){1'b0}}, cfg_q.open_dist};
      REG_SIDE_ENTER:   prdata = {{(DataW-DistW){1'b0}}, cfg_q.enter_dist};
      REG_SIDE_NEAR:    prdata = {{(DataW-DistW){1'b0}}, cfg_q.near_dist};
      REG_TURN_TIMEOUT: prdata = {{(DataW-TcfgW){1'b0}}, cfg_q.turn_limit};
      REG_POST_TURN:    prdata = {{(DataW-TcfgW){1'b0}}, cfg_q.settle_time};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/wfd_step.sv]
// Per-tick decision logic of the wall follower drive controller: from one
// sensor tick, the configuration and the current state it forms the motor
// command and the next state. Purely combinational. Depends on wfd_pkg.
module wfd_step (
  input  wfd_pkg::in_item_t  item_i,
  input  wfd_pkg::cfg_t      cfg_i,
  input  wfd_pkg::state_t    state_i,
  output wfd_pkg::out_item_t res_o,
  output wfd_pkg::state_t    state_o
);
  import wfd_pkg::*;

  logic [TimeW-1:0]  elapsed;
  logic [SpeedW-1:0] base_spd;
  logic [SpeedW-1:0] lsp, rsp;
  logic [2:0]        action;
  logic [1:0]        event_code;
  logic              left_free, right_free;
  logic              left_near, right_near;
  logic              drift_right, drift_left;
  logic [DistW-1:0]  side_dist;
  logic              turn_done;
  state_t            st;

  // Time since the turn started, modulo 2^32.
  assign elapsed = item_i.now_ms - state_i.turn_start;

  // Distance comparisons used in drive and pre-turn.
  assign base_spd   = (item_i.front_dist < cfg_i.slow_dist) ? SPEED_APPROACH
                                                            : SPEED_FAST;
  assign left_near  = (item_i.left_dist <= cfg_i.near_dist) &&
                      (item_i.left_dist < item_i.right_dist);
  assign right_near = (item_i.right_dist <= cfg_i.near_dist) &&
                      (item_i.right_dist < item_i.left_dist);
  // Left minus right beyond the centering band, either way.
  assign drift_right = {1'b0, item_i.left_dist} > ({1'b0, item_i.right_dist} + CENTRE_BAND);
  assign drift_left  = {1'b0, item_i.right_dist} > ({1'b0, item_i.left_dist} + CENTRE_BAND);
  assign left_free   = item_i.left_dist >= cfg_i.open_dist;
  assign right_free  = item_i.right_dist >= cfg_i.open_dist;

  // A turn finishes on clear front plus a wall on the turning side, or timeout.
  assign side_dist = (state_i.mode == MODE_LEFT) ? item_i.left_dist : item_i.right_dist;
  assign turn_done = ((item_i.front_dist > cfg_i.clear_dist) &&
                      (side_dist < cfg_i.enter_dist)) ||
                     (elapsed > {{(TimeW-TcfgW){1'b0}}, cfg_i.turn_limit});

  // Mode transitions and command selection.
  always_comb begin
    st         = state_i;
    action     = ACT_HOLD;
    lsp        = '0;
    rsp        = '0;
    event_code = EV_NONE;
    unique case (state_i.mode)
      MODE_DRIVE: begin
        if (item_i.front_dist < cfg_i.stop_dist) begin
          st.mode = MODE_PRE;
        end else begin
          action = ACT_FWD;
          priority if (left_near) begin
            lsp = SPEED_SLOW;
            rsp = SPEED_SLOW - STEER_STRONG;
          end else if (right_near) begin
            lsp = SPEED_SLOW - STEER_STRONG;
            rsp = SPEED_SLOW;
          end else if (drift_right) begin
            lsp = base_spd - STEER_SMALL;
            rsp = base_spd;
          end else if (drift_left) begin
            lsp = base_spd;
            rsp = base_spd - STEER_SMALL;
          end else begin
            lsp = base_spd;
            rsp = base_spd;
          end
        end
      end
      MODE_PRE: begin
        action        = ACT_STOP;
        st.turn_start = item_i.now_ms;
        priority if (right_free && !left_free) begin
          event_code = EV_RIGHT;
          st.turn_cnt = state_i.turn_cnt + 8'd1;
          st.mode     = MODE_RIGHT;
        end else if (left_free) begin
          event_code = EV_LEFT;
          st.turn_cnt = state_i.turn_cnt + 8'd1;
          st.mode     = MODE_LEFT;
        end else begin
          // Dead end: counted as two left turns.
          event_code = EV_DEAD;
          st.turn_cnt = state_i.turn_cnt + 8'd2;
          st.mode     = MODE_LEFT;
        end
      end
      MODE_LEFT, MODE_RIGHT: begin
        action = (state_i.mode == MODE_LEFT) ? ACT_SPIN_L : ACT_SPIN_R;
        if (turn_done) begin
          action        = (state_i.mode == MODE_LEFT) ? ACT_BRAKE_L : ACT_BRAKE_R;
          st.turn_start = item_i.now_ms;
          st.mode       = MODE_POST;
        end
      end
      MODE_POST: begin
        action = ACT_FWD;
        lsp    = SPEED_SLOW;
        rsp    = SPEED_SLOW;
        if (elapsed >= {{(TimeW-TcfgW){1'b0}}, cfg_i.settle_time}) begin
          st.mode = MODE_DRIVE;
        end
      end
      default: begin
        st.mode = MODE_DRIVE;
      end
    endcase
  end

  assign state_o            = st;
  assign res_o.motor_action = action;
  assign res_o.left_speed   = lsp;
  assign res_o.right_speed  = rsp;
  assign res_o.turn_event   = event_code;
  assign res_o.turn_total   = st.turn_cnt;
  assign res_o.mode_now     = mode_code(st.mode);

endmodule
